/* rtl/utrf_pkg.sv */
// utrf_pkg: queue depths, index widths, transaction types and index helpers
// for the uart byte fifo pair; no dependencies
package utrf_pkg;

  localparam int TX_DEPTH = 16;
  localparam int RX_DEPTH = 16;
  localparam int TX_RANGE = 2 * TX_DEPTH;
  localparam int RX_RANGE = 2 * RX_DEPTH;
  localparam int TX_PW    = $clog2(TX_RANGE);
  localparam int RX_PW    = $clog2(RX_RANGE);
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_AW    = $clog2(RX_DEPTH);

  typedef enum logic [2:0] {
    FN_HOST_WRITE = 3'd0,
    FN_HOST_READ  = 3'd1,
    FN_LINE_RX    = 3'd2,
    FN_TX_READY   = 3'd3,
    FN_FLUSH      = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  read_byte;
    logic [7:0]  line_byte;
    logic        line_byte_valid;
    logic        tx_irq_enable;
    logic [7:0]  rx_fill;
    logic [7:0]  tx_fill;
    logic [31:0] received_total;
    logic [31:0] sent_total;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [TX_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [TX_AW-1:0] raddr;
  } tx_cmd_t;

  typedef struct packed {
    logic             we;
    logic [RX_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [RX_AW-1:0] raddr;
  } rx_cmd_t;

  typedef struct packed {
    logic        status;
    logic        sel_rd;
    logic        lbv;
    logic        irq;
    logic [7:0]  rx_fill;
    logic [7:0]  tx_fill;
    logic [31:0] recv;
    logic [31:0] sent;
  } pend_t;

  function automatic logic [TX_PW-1:0] tx_fill_f(input logic [TX_PW-1:0] put,
                                                  input logic [TX_PW-1:0] take);
    logic [TX_PW:0] d;
    d = {1'b0, put} - {1'b0, take};
    if (put < take) d = d + (TX_PW+1)'(TX_RANGE);
    return d[TX_PW-1:0];
  endfunction

  function automatic logic [RX_PW-1:0] rx_fill_f(input logic [RX_PW-1:0] put,
                                                  input logic [RX_PW-1:0] take);
    logic [RX_PW:0] d;
    d = {1'b0, put} - {1'b0, take};
    if (put < take) d = d + (RX_PW+1)'(RX_RANGE);
    return d[RX_PW-1:0];
  endfunction

  function automatic logic [TX_PW-1:0] tx_adv_f(input logic [TX_PW-1:0] idx);
    return (idx == TX_PW'(TX_RANGE - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [RX_PW-1:0] rx_adv_f(input logic [RX_PW-1:0] idx);
    return (idx == RX_PW'(RX_RANGE - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [TX_AW-1:0] tx_addr_f(input logic [TX_PW-1:0] idx);
    logic [TX_PW-1:0] a;
    a = (idx >= TX_PW'(TX_DEPTH)) ? idx - TX_PW'(TX_DEPTH) : idx;
    return a[TX_AW-1:0];
  endfunction

  function automatic logic [RX_AW-1:0] rx_addr_f(input logic [RX_PW-1:0] idx);
    logic [RX_PW-1:0] a;
    a = (idx >= RX_PW'(RX_DEPTH)) ? idx - RX_PW'(RX_DEPTH) : idx;
    return a[RX_AW-1:0];
  endfunction

endpackage

/* rtl/utrf_ram.sv */
// utrf_ram: generic single-write, single-read synchronous ram with
// registered read data; no dependencies
module utrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* rtl/utrf_ctrl.sv */
// utrf_ctrl: queue indices, idle flag and totals; decodes each transaction
// and issues ram accesses; depends on utrf_pkg
module utrf_ctrl import utrf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  in_t     in_data,
  input  logic    busy,
  output logic    in_stall,
  output tx_cmd_t tx_cmd,
  output rx_cmd_t rx_cmd,
  output logic    pend_valid,
  output pend_t   pend
);

  logic [TX_PW-1:0] tx_put_r, tx_put_nxt, tx_take_r, tx_take_nxt;
  logic [RX_PW-1:0] rx_put_r, rx_put_nxt, rx_take_r, rx_take_nxt;
  logic             tx_idle_r, tx_idle_nxt;
  logic [31:0]      recv_r, recv_nxt, sent_r, sent_nxt;
  logic [TX_PW-1:0] tx_fill;
  logic [RX_PW-1:0] rx_fill;
  logic             accept;
  logic             status;
  logic             sel_rd;
  logic             lbv;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign tx_fill  = tx_fill_f(tx_put_r, tx_take_r);
  assign rx_fill  = rx_fill_f(rx_put_r, rx_take_r);

  always_comb begin
    tx_put_nxt  = tx_put_r;
    tx_take_nxt = tx_take_r;
    rx_put_nxt  = rx_put_r;
    rx_take_nxt = rx_take_r;
    tx_idle_nxt = tx_idle_r;
    recv_nxt    = recv_r;
    sent_nxt    = sent_r;
    status      = 1'b1;
    sel_rd      = 1'b0;
    lbv         = 1'b0;
    tx_cmd      = '{we: 1'b0, waddr: tx_addr_f(tx_put_r), wdata: in_data.data_byte,
                    re: 1'b0, raddr: tx_addr_f(tx_take_r)};
    rx_cmd      = '{we: 1'b0, waddr: rx_addr_f(rx_put_r), wdata: in_data.data_byte,
                    re: 1'b0, raddr: rx_addr_f(rx_take_r)};
    if (accept) begin
      unique case (in_data.func)
        FN_HOST_WRITE: begin
          if (tx_fill != TX_PW'(TX_DEPTH)) begin
            tx_cmd.we   = 1'b1;
            tx_put_nxt  = tx_adv_f(tx_put_r);
            tx_idle_nxt = 1'b0;
            status      = 1'b0;
          end
        end
        FN_HOST_READ: begin
          if (rx_fill != '0) begin
            rx_cmd.re   = 1'b1;
            rx_take_nxt = rx_adv_f(rx_take_r);
            sel_rd      = 1'b1;
            status      = 1'b0;
          end
        end
        FN_LINE_RX: begin
          if (rx_fill != RX_PW'(RX_DEPTH)) begin
            rx_cmd.we  = 1'b1;
            rx_put_nxt = rx_adv_f(rx_put_r);
            recv_nxt   = recv_r + 32'd1;
            status     = 1'b0;
          end
        end
        FN_TX_READY: begin
          if (tx_fill != '0) begin
            tx_cmd.re   = 1'b1;
            tx_take_nxt = tx_adv_f(tx_take_r);
            tx_idle_nxt = 1'b0;
            sent_nxt    = sent_r + 32'd1;
            lbv         = 1'b1;
            status      = 1'b0;
          end else begin
            tx_idle_nxt = 1'b1;
          end
        end
        FN_FLUSH: begin
          tx_put_nxt  = '0;
          tx_take_nxt = '0;
          rx_put_nxt  = '0;
          rx_take_nxt = '0;
          tx_idle_nxt = 1'b1;
          status      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign pend_valid   = accept;
  assign pend.status  = status;
  assign pend.sel_rd  = sel_rd;
  assign pend.lbv     = lbv;
  assign pend.irq     = !tx_idle_nxt;
  assign pend.rx_fill = 8'(rx_fill_f(rx_put_nxt, rx_take_nxt));
  assign pend.tx_fill = 8'(tx_fill_f(tx_put_nxt, tx_take_nxt));
  assign pend.recv    = recv_nxt;
  assign pend.sent    = sent_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_put_r  <= '0;
      tx_take_r <= '0;
      rx_put_r  <= '0;
      rx_take_r <= '0;
      tx_idle_r <= 1'b1;
      recv_r    <= '0;
      sent_r    <= '0;
    end else begin
      tx_put_r  <= tx_put_nxt;
      tx_take_r <= tx_take_nxt;
      rx_put_r  <= rx_put_nxt;
      rx_take_r <= rx_take_nxt;
      tx_idle_r <= tx_idle_nxt;
      recv_r    <= recv_nxt;
      sent_r    <= sent_nxt;
    end
  end

endmodule

/* rtl/utrf_resp.sv */
// utrf_resp: holds a transaction while its ram read completes, then the
// output register; depends on utrf_pkg
module utrf_resp import utrf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pend_valid,
  input  pend_t      pend,
  input  logic [7:0] tx_rdata,
  input  logic [7:0] rx_rdata,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data
);

  logic  s1_vld_r;
  pend_t s1_r;
  logic  out_vld_r;
  out_t  out_r;
  out_t  out_nxt;

  assign busy = s1_vld_r || (out_vld_r && out_stall);

  always_comb begin
    out_nxt.status          = s1_r.status;
    out_nxt.read_byte       = s1_r.sel_rd ? rx_rdata : 8'd0;
    out_nxt.line_byte       = s1_r.lbv ? tx_rdata : 8'd0;
    out_nxt.line_byte_valid = s1_r.lbv;
    out_nxt.tx_irq_enable   = s1_r.irq;
    out_nxt.rx_fill         = s1_r.rx_fill;
    out_nxt.tx_fill         = s1_r.tx_fill;
    out_nxt.received_total  = s1_r.recv;
    out_nxt.sent_total      = s1_r.sent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= pend_valid;
      if (s1_vld_r) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid) s1_r <= pend;
    if (s1_vld_r) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

/* rtl/uart_tx_rx_byte_fifos_unit.sv */
// uart_tx_rx_byte_fifos_unit: transmit and receive byte queues between a host
// and a serial line; depends on utrf_pkg, utrf_ram, utrf_ctrl, utrf_resp
//
//   channel  handshake            payload
//   in_      in_valid / in_stall  in_t  (func, data_byte)
//   out_     out_valid/ out_stall out_t (status .. sent_total)
//
// one transaction at a time: indices update and the ram is accessed at
// acceptance, the registered ram read lands in the output register in the
// following cycle; the next transaction is taken once that register is free
// reset clears indices, totals and sets the transmitter idle; ram contents
// are not cleared; a stalled result holds and blocks new input
module uart_tx_rx_byte_fifos_unit import utrf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  tx_cmd_t    tx_cmd;
  rx_cmd_t    rx_cmd;
  logic       pend_valid;
  pend_t      pend;
  logic       busy;
  logic [7:0] tx_rdata;
  logic [7:0] rx_rdata;

  utrf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .busy       (busy),
    .in_stall   (in_stall),
    .tx_cmd     (tx_cmd),
    .rx_cmd     (rx_cmd),
    .pend_valid (pend_valid),
    .pend       (pend)
  );

  utrf_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_cmd.we),
    .waddr (tx_cmd.waddr),
    .wdata (tx_cmd.wdata),
    .re    (tx_cmd.re),
    .raddr (tx_cmd.raddr),
    .rdata (tx_rdata)
  );

  utrf_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_cmd.we),
    .waddr (rx_cmd.waddr),
    .wdata (rx_cmd.wdata),
    .re    (rx_cmd.re),
    .raddr (rx_cmd.raddr),
    .rdata (rx_rdata)
  );

  utrf_resp u_resp (
    .clk        (clk),
    .rst_n      (rst_n),
    .pend_valid (pend_valid),
    .pend       (pend),
    .tx_rdata   (tx_rdata),
    .rx_rdata   (rx_rdata),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
